// File: rtl/totalistic_automaton_row_step_macros.svh
// Assertion helpers shared by the row step modules.
`ifndef TOTALISTIC_AUTOMATON_ROW_STEP_MACROS_SVH
`define TOTALISTIC_AUTOMATON_ROW_STEP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TARS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tars: invariant violated");
`define TARS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tars: implication violated");
`define TARS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tars: next-cycle check violated");
`else
`define TARS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define TARS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TARS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/tars_pkg.sv
package tars_pkg;

    localparam int MAX_RADIUS  = 7;
    localparam int MAX_COLUMNS = 4096;
    localparam int RULE_DIGITS = 16;

    localparam int MIN_STATES = 2;
    localparam int MAX_STATES = 6;

    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
    localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int CELL_W      = 8;
    localparam int STATE_W     = 3;
    localparam int DIGIT_W     = 3;
    localparam int RULE_W      = RULE_DIGITS * DIGIT_W;
    localparam int DIGIT_IDX_W = $clog2(RULE_DIGITS);
    localparam int SUM_W       = 12;
    localparam int LEN_W       = $clog2(WIN_DEPTH * (MAX_STATES - 1) + 2);
    localparam int LFSR_W      = 16;
    localparam int LAST_W      = 12;
    localparam int RADIUS_W    = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RULE_W;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_TABLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_COLUMN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_RAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_SEED  = 3'd5;

    localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEFT,
        S_MID,
        S_RIGHT
    } state_t;

    typedef struct packed {
        logic [STATE_W-1:0] k_eff;
        logic [RAD_W-1:0]   r_eff;
        logic [COL_W-1:0]   last_eff;
        logic [RULE_W-1:0]  rule;
        logic               random;
        logic               seed_load;
        logic [LFSR_W-1:0]  seed;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic emit_border;
        logic emit_mid;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic mid;
        logic last_item;
        logic slot_free;
        logic left_done;
        logic right_done;
    } sts_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] x);
        logic [LFSR_W-1:0] y;
        y = x >> 1;
        if (x[0])
        begin
            y = y ^ LFSR_MASK;
        end
        return y;
    endfunction

    // x mod k for k in 2..6, by digit sums: 4 = 1 mod 3, 16 = 1 mod 5
    function automatic logic [STATE_W-1:0] mod_states(input logic [LFSR_W-1:0] x,
                                                      input logic [STATE_W-1:0] k);
        logic [4:0]         s3;
        logic [3:0]         t3;
        logic [5:0]         s5;
        logic [4:0]         t5;
        logic [STATE_W-1:0] m3;
        logic [STATE_W-1:0] m5;
        logic [STATE_W-1:0] res;
        s3 = '0;
        for (int i = 0; i < LFSR_W / 2; i++)
        begin
            s3 = s3 + 5'(x[2*i +: 2]);
        end
        t3 = 4'(s3[4:2]) + 4'(s3[1:0]);
        if (t3 >= 4'd6)
        begin
            t3 = t3 - 4'd6;
        end
        if (t3 >= 4'd3)
        begin
            t3 = t3 - 4'd3;
        end
        m3 = 3'(t3);
        s5 = '0;
        for (int i = 0; i < LFSR_W / 4; i++)
        begin
            s5 = s5 + 6'(x[4*i +: 4]);
        end
        t5 = 5'(s5[5:4]) + 5'(s5[3:0]);
        if (t5 >= 5'd15)
        begin
            t5 = t5 - 5'd15;
        end
        else if (t5 >= 5'd10)
        begin
            t5 = t5 - 5'd10;
        end
        else if (t5 >= 5'd5)
        begin
            t5 = t5 - 5'd5;
        end
        m5 = 3'(t5);
        case (k)
            3'd3:    res = m3;
            3'd4:    res = {1'b0, x[1:0]};
            3'd5:    res = m5;
            3'd6:    res = (m3[0] == x[0]) ? m3 : m3 + 3'd3;
            default: res = {2'b00, x[0]};
        endcase
        return res;
    endfunction

endpackage

// File: rtl/totalistic_automaton_row_step.sv
// One generation of a one-dimensional totalistic automaton arrives as a stream of
// old cells in column order, one word per cell; new cells leave in column order as
// words of their own. An old cell is taken while the controller is idle, and its
// results then leave through the single output register at one word per cycle
// while out_stall is low: column 0 yields the r left border cells, the last
// column yields the r+1 right border cells, columns 2r up to the one before the
// last yield one interior cell each, and columns 1 to 2r-1 yield none. The
// controller serves one old cell at a time, and the output register lets the next
// cell in while the final word still waits. Write the registers only between rows
// or with the block drained; writing border_seed reloads the border generator.
module totalistic_automaton_row_step
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tars_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tars_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tars_pkg::CELL_W-1:0]      old_cell,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tars_pkg::STATE_W-1:0]     new_cell,
    output logic [tars_pkg::COL_W-1:0]       column,
    output logic                             is_border,
    output logic                             bad_sum,
    output logic                             row_end
);

    tars_pkg::cfg_t cfg;
    tars_pkg::cmd_t cmd;
    tars_pkg::sts_t sts;

    tars_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tars_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tars_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .old_cell  (old_cell),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .new_cell  (new_cell),
        .column    (column),
        .is_border (is_border),
        .bad_sum   (bad_sum),
        .row_end   (row_end)
    );

endmodule

// File: rtl/tars_cfg.sv
module tars_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tars_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tars_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tars_pkg::cfg_t                   cfg
);

    logic [tars_pkg::STATE_W-1:0]  num_states_reg;
    logic [tars_pkg::RADIUS_W-1:0] radius_reg;
    logic [tars_pkg::RULE_W-1:0]   rule_reg;
    logic [tars_pkg::LAST_W-1:0]   last_reg;
    logic                          random_reg;
    logic                          wr;
    logic [tars_pkg::LFSR_W-1:0]   seed_in;
    logic [tars_pkg::COL_W-1:0]    last_lim;
    logic [tars_pkg::COL_W-1:0]    two_r;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign seed_in   = cfg_data[tars_pkg::LFSR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= tars_pkg::STATE_W'(2);
            radius_reg     <= tars_pkg::RADIUS_W'(1);
            rule_reg       <= '0;
            last_reg       <= tars_pkg::LAST_W'(639);
            random_reg     <= 1'b0;
        end
        else if (wr)
        begin
            case (cfg_index)
                tars_pkg::REG_NUM_STATES:  num_states_reg <= cfg_data[tars_pkg::STATE_W-1:0];
                tars_pkg::REG_RADIUS:      radius_reg <= cfg_data[tars_pkg::RADIUS_W-1:0];
                tars_pkg::REG_RULE_TABLE:  rule_reg <= cfg_data[tars_pkg::RULE_W-1:0];
                tars_pkg::REG_LAST_COLUMN: last_reg <= cfg_data[tars_pkg::LAST_W-1:0];
                tars_pkg::REG_BORDER_RAND: random_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        if (num_states_reg < tars_pkg::STATE_W'(tars_pkg::MIN_STATES))
        begin
            cfg.k_eff = tars_pkg::STATE_W'(tars_pkg::MIN_STATES);
        end
        else if (num_states_reg > tars_pkg::STATE_W'(tars_pkg::MAX_STATES))
        begin
            cfg.k_eff = tars_pkg::STATE_W'(tars_pkg::MAX_STATES);
        end
        else
        begin
            cfg.k_eff = num_states_reg;
        end

        if (radius_reg == '0)
        begin
            cfg.r_eff = tars_pkg::RAD_W'(1);
        end
        else if (32'(radius_reg) > tars_pkg::MAX_RADIUS)
        begin
            cfg.r_eff = tars_pkg::RAD_W'(tars_pkg::MAX_RADIUS);
        end
        else
        begin
            cfg.r_eff = tars_pkg::RAD_W'(radius_reg);
        end

        // limit to MAX_COLUMNS - 1, then widen to at least 2r to fit both borders
        if (32'(last_reg) > tars_pkg::MAX_COLUMNS - 1)
        begin
            last_lim = tars_pkg::COL_W'(tars_pkg::MAX_COLUMNS - 1);
        end
        else
        begin
            last_lim = tars_pkg::COL_W'(last_reg);
        end
        two_r = tars_pkg::COL_W'({cfg.r_eff, 1'b0});
        cfg.last_eff  = (last_lim < two_r) ? two_r : last_lim;
        cfg.rule      = rule_reg;
        cfg.random    = random_reg;
        cfg.seed_load = wr && (cfg_index == tars_pkg::REG_BORDER_SEED);
        cfg.seed      = (seed_in == '0) ? tars_pkg::LFSR_RESET : seed_in;
    end

endmodule

// File: rtl/tars_ctrl.sv
`include "totalistic_automaton_row_step_macros.svh"

module tars_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  tars_pkg::sts_t  sts,
    output tars_pkg::cmd_t  cmd
);

    tars_pkg::state_t state_reg;
    tars_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tars_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd.take        = 1'b0;
        cmd.emit_border = 1'b0;
        cmd.emit_mid    = 1'b0;
        in_stall        = 1'b1;
        case (state_reg)
            tars_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.first)
                    begin
                        state_next = tars_pkg::S_LEFT;
                    end
                    else if (sts.mid)
                    begin
                        state_next = tars_pkg::S_MID;
                    end
                    else if (sts.last_item)
                    begin
                        state_next = tars_pkg::S_RIGHT;
                    end
                end
            end
            tars_pkg::S_LEFT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_border = 1'b1;
                    if (sts.left_done)
                    begin
                        state_next = tars_pkg::S_IDLE;
                    end
                end
            end
            tars_pkg::S_MID:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_mid = 1'b1;
                    state_next   = tars_pkg::S_IDLE;
                end
            end
            tars_pkg::S_RIGHT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_border = 1'b1;
                    if (sts.right_done)
                    begin
                        state_next = tars_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tars_pkg::S_IDLE;
            end
        endcase
    end

    `TARS_ASSERT_ALWAYS(a_no_take_while_emit, clk, rst_n, !(cmd.take && (cmd.emit_border || cmd.emit_mid)))
    `TARS_ASSERT_NEXT(a_mid_follows_take, clk, rst_n, cmd.take && !sts.first && sts.mid, state_reg == tars_pkg::S_MID)
    `TARS_ASSERT_NEXT(a_mid_single_word, clk, rst_n, state_reg == tars_pkg::S_MID && sts.slot_free, state_reg == tars_pkg::S_IDLE)

endmodule

// File: rtl/tars_dp.sv
`include "totalistic_automaton_row_step_macros.svh"

module tars_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tars_pkg::cfg_t                 cfg,
    input  tars_pkg::cmd_t                 cmd,
    output tars_pkg::sts_t                 sts,
    input  logic [tars_pkg::CELL_W-1:0]    old_cell,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tars_pkg::STATE_W-1:0]   new_cell,
    output logic [tars_pkg::COL_W-1:0]     column,
    output logic                           is_border,
    output logic                           bad_sum,
    output logic                           row_end
);

    logic [tars_pkg::CELL_W-1:0]  window_reg [tars_pkg::WIN_DEPTH];
    logic [tars_pkg::CELL_W-1:0]  window_next [tars_pkg::WIN_DEPTH];
    logic [tars_pkg::SUM_W-1:0]   sum_reg;
    logic [tars_pkg::SUM_W-1:0]   sum_next;
    logic [tars_pkg::COL_W-1:0]   count_reg;
    logic [tars_pkg::COL_W-1:0]   cur_col_reg;
    logic [tars_pkg::COL_W-1:0]   bcol_reg;
    logic [tars_pkg::LFSR_W-1:0]  lfsr_reg;
    logic                         out_valid_reg;
    logic [tars_pkg::STATE_W-1:0] new_cell_reg;
    logic [tars_pkg::COL_W-1:0]   column_reg;
    logic                         is_border_reg;
    logic                         bad_sum_reg;
    logic                         row_end_reg;

    logic                         first;
    logic [tars_pkg::CELL_W-1:0]  leaving;
    logic [tars_pkg::SUM_W-1:0]   sum_base;
    logic [tars_pkg::COL_W-1:0]   two_r;
    logic [tars_pkg::COL_W-1:0]   r_col;
    logic [tars_pkg::LFSR_W-1:0]  lfsr_stepped;
    logic [tars_pkg::STATE_W-1:0] border_cell;
    logic [tars_pkg::RAD_W:0]     rad2p1;
    logic [tars_pkg::STATE_W-1:0] k_m1;
    logic [tars_pkg::LEN_W-1:0]   rule_len;
    logic                         mid_bad;
    logic [tars_pkg::DIGIT_W-1:0] digit;
    logic [tars_pkg::STATE_W-1:0] mid_cell;

    assign first = (count_reg == '0);
    assign two_r = tars_pkg::COL_W'({cfg.r_eff, 1'b0});
    assign r_col = tars_pkg::COL_W'(cfg.r_eff);

    // shift the window; the first column of a row starts from a clear window
    always_comb
    begin
        leaving = first ? '0 : window_reg[tars_pkg::WIN_IDX_W'({cfg.r_eff, 1'b0})];
        window_next[0] = old_cell;
        for (int i = 1; i < tars_pkg::WIN_DEPTH; i++)
        begin
            window_next[i] = first ? '0 : window_reg[i-1];
        end
        sum_base = first ? '0 : sum_reg;
        sum_next = sum_base + tars_pkg::SUM_W'(old_cell) - tars_pkg::SUM_W'(leaving);
    end

    always_comb
    begin
        lfsr_stepped = tars_pkg::lfsr_step(lfsr_reg);
        border_cell  = cfg.random ? tars_pkg::mod_states(lfsr_stepped, cfg.k_eff) : '0;

        rad2p1   = {cfg.r_eff, 1'b1};
        k_m1     = cfg.k_eff - 3'd1;
        rule_len = tars_pkg::LEN_W'(tars_pkg::LEN_W'(rad2p1) * tars_pkg::LEN_W'(k_m1))
                 + tars_pkg::LEN_W'(1);
        mid_bad  = (sum_reg >= tars_pkg::SUM_W'(rule_len))
                || (sum_reg >= tars_pkg::SUM_W'(tars_pkg::RULE_DIGITS));
        digit    = cfg.rule[sum_reg[tars_pkg::DIGIT_IDX_W-1:0] * tars_pkg::DIGIT_W
                            +: tars_pkg::DIGIT_W];
        if (mid_bad)
        begin
            mid_cell = '0;
        end
        else if (digit > k_m1)
        begin
            mid_cell = k_m1;
        end
        else
        begin
            mid_cell = digit;
        end
    end

    always_comb
    begin
        sts.first      = first;
        sts.mid        = (count_reg >= two_r) && (count_reg < cfg.last_eff);
        sts.last_item  = (count_reg >= cfg.last_eff);
        sts.slot_free  = !out_valid_reg || !out_stall;
        sts.left_done  = (bcol_reg == r_col - tars_pkg::COL_W'(1));
        sts.right_done = (bcol_reg == cfg.last_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            bcol_reg      <= '0;
            lfsr_reg      <= tars_pkg::LFSR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.seed_load)
            begin
                lfsr_reg <= cfg.seed;
            end
            else if (cmd.emit_border && cfg.random)
            begin
                lfsr_reg <= lfsr_stepped;
            end

            if (cmd.take)
            begin
                count_reg <= sts.last_item ? '0 : count_reg + tars_pkg::COL_W'(1);
                bcol_reg  <= first ? '0 : cfg.last_eff - r_col;
            end
            else if (cmd.emit_border)
            begin
                bcol_reg <= bcol_reg + tars_pkg::COL_W'(1);
            end

            if (cmd.emit_border || cmd.emit_mid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            for (int i = 0; i < tars_pkg::WIN_DEPTH; i++)
            begin
                window_reg[i] <= window_next[i];
            end
            sum_reg     <= sum_next;
            cur_col_reg <= count_reg;
        end
        if (cmd.emit_border)
        begin
            new_cell_reg  <= border_cell;
            column_reg    <= bcol_reg;
            is_border_reg <= 1'b1;
            bad_sum_reg   <= 1'b0;
            row_end_reg   <= (bcol_reg == cfg.last_eff);
        end
        else if (cmd.emit_mid)
        begin
            new_cell_reg  <= mid_cell;
            column_reg    <= cur_col_reg - r_col;
            is_border_reg <= 1'b0;
            bad_sum_reg   <= mid_bad;
            row_end_reg   <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_cell  = new_cell_reg;
    assign column    = column_reg;
    assign is_border = is_border_reg;
    assign bad_sum   = bad_sum_reg;
    assign row_end   = row_end_reg;

    `TARS_ASSERT_IMPLY(a_bad_sum_cell, clk, rst_n, out_valid_reg && bad_sum_reg, new_cell_reg == '0 && !is_border_reg)
    `TARS_ASSERT_IMPLY(a_row_end_border, clk, rst_n, out_valid_reg && row_end_reg, is_border_reg)
    `TARS_ASSERT_ALWAYS(a_lfsr_nonzero, clk, rst_n, lfsr_reg != '0)

endmodule
